FILE: hw/rtl/fdw_pkg.sv
`timescale 1ns / 1ps
// shared types and constants of the fall detector with recovery watchdog
package fdw_pkg;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QPtrW      = $clog2(QueueDepth);
  localparam int unsigned QLvlW      = $clog2(QueueDepth + 1);

  localparam logic [7:0]  RunMax   = 8'hFF;
  localparam logic [23:0] MsMax    = 24'hFF_FFFF;

  localparam logic [31:0] SpikeReset    = 32'd104857600;
  localparam logic [31:0] BandHighReset = 32'd28353495;
  localparam logic [31:0] BandLowReset  = 32'd8220835;
  localparam logic [7:0]  MovesReset    = 8'd5;
  localparam logic [23:0] LimitReset    = 24'd30000;

  typedef enum logic [2:0] {
    IDX_SPIKE_LEVEL = 3'd0,
    IDX_BAND_HIGH   = 3'd1,
    IDX_BAND_LOW    = 3'd2,
    IDX_MOVES       = 3'd3,
    IDX_LIMIT       = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [31:0] spike_level_sq;
    logic [31:0] band_high_sq;
    logic [31:0] band_low_sq;
    logic [7:0]  moves_to_clear;
    logic [23:0] no_recovery_limit_ms;
  } cfg_t;

  // classified word handed from front to back
  typedef struct packed {
    logic tick;
    logic spike;
    logic move;
  } cls_t;

  // magnitude of a signed q4.12 axis, 0..32768 fits in 16 bits
  function automatic logic [15:0] axis_mag(input logic [15:0] v);
    logic [15:0] neg;
    neg = ~v + 16'd1;
    return v[15] ? neg : v;
  endfunction

endpackage

FILE: hw/rtl/fdw_front.sv
`timescale 1ns / 1ps
// front end: squares the axes, sums and classifies each word
module fdw_front import fdw_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cfg_t              cfg_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              action_i,
  input  logic signed [15:0] accel_x_i,
  input  logic signed [15:0] accel_y_i,
  input  logic signed [15:0] accel_z_i,
  input  logic [QLvlW-1:0]  q_level_i,
  output logic              push_o,
  output cls_t              push_word_o
);

  logic        sq_valid_q;
  logic        tick_q;
  logic [31:0] sq_x_q, sq_y_q, sq_z_q;
  logic [15:0] mag_x, mag_y, mag_z;
  logic [31:0] mag_sq;
  logic        accept;

  // reserve a queue slot for the word in the square stage
  assign in_stall_o = (QLvlW'(sq_valid_q) + q_level_i) >= QLvlW'(QueueDepth);
  assign accept     = in_valid_i && !in_stall_o;

  assign mag_x = axis_mag(accel_x_i);
  assign mag_y = axis_mag(accel_y_i);
  assign mag_z = axis_mag(accel_z_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_valid_q <= 1'b0;
    end else begin
      sq_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      tick_q <= action_i;
      sq_x_q <= 32'(mag_x) * 32'(mag_x);
      sq_y_q <= 32'(mag_y) * 32'(mag_y);
      sq_z_q <= 32'(mag_z) * 32'(mag_z);
    end
  end

  // at most 3 * 2^30, no carry out of 32 bits
  assign mag_sq = sq_x_q + sq_y_q + sq_z_q;

  assign push_o            = sq_valid_q;
  assign push_word_o.tick  = tick_q;
  assign push_word_o.spike = mag_sq > cfg_i.spike_level_sq;
  assign push_word_o.move  = (mag_sq > cfg_i.band_high_sq) || (mag_sq < cfg_i.band_low_sq);

endmodule

FILE: hw/rtl/fdw_queue.sv
`timescale 1ns / 1ps
// short word queue between the front and back ends
module fdw_queue import fdw_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  cls_t             push_word_i,
  input  logic             pop_i,
  output logic             empty_o,
  output cls_t             head_o,
  output logic [QLvlW-1:0] level_o
);

  cls_t             slots_q [QueueDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QLvlW-1:0] level_q;

  assign empty_o = (level_q == '0);
  assign head_o  = slots_q[rd_ptr_q];
  assign level_o = level_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + QPtrW'(1);
      if (pop_i) rd_ptr_q <= rd_ptr_q + QPtrW'(1);
      if (push_i && !pop_i) begin
        level_q <= level_q + QLvlW'(1);
      end else if (pop_i && !push_i) begin
        level_q <= level_q - QLvlW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) slots_q[wr_ptr_q] <= push_word_i;
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (level_q != QLvlW'(QueueDepth)) || pop_i)
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("queue pop while empty");

  a_level_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    level_q <= QLvlW'(QueueDepth))
    else $error("queue level out of range");

endmodule

FILE: hw/rtl/fdw_back.sv
`timescale 1ns / 1ps
// back end: fall state, recovery run, elapsed time and the result register
module fdw_back import fdw_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  cfg_t cfg_i,
  input  logic q_empty_i,
  input  cls_t q_head_i,
  output logic pop_o,
  output logic out_valid_o,
  input  logic out_stall_i,
  output logic fall_flag_o,
  output logic watchdog_expired_o
);

  logic        armed_q, armed_d;
  logic [7:0]  run_q, run_d;
  logic [23:0] since_q, since_d;
  logic        out_valid_q;
  logic        fall_q, wd_q;

  assign pop_o = !q_empty_i && (!out_valid_q || !out_stall_i);

  always_comb begin
    armed_d = armed_q;
    run_d   = run_q;
    since_d = since_q;
    if (q_head_i.tick) begin
      if (since_q != MsMax) since_d = since_q + 24'd1;
    end else begin
      if (q_head_i.spike && !armed_q) begin
        armed_d = 1'b1;
        since_d = '0;
        run_d   = '0;
      end
      if (armed_d) begin
        if (q_head_i.move) begin
          if (run_d != RunMax) run_d = run_d + 8'd1;
        end else begin
          run_d = '0;
        end
        if (run_d >= cfg_i.moves_to_clear) begin
          armed_d = 1'b0;
          run_d   = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q     <= 1'b0;
      run_q       <= '0;
      since_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        armed_q <= armed_d;
        run_q   <= run_d;
        since_q <= since_d;
      end
      if (pop_o) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      fall_q <= armed_d;
      wd_q   <= armed_d && (since_d > cfg_i.no_recovery_limit_ms);
    end
  end

  assign out_valid_o        = out_valid_q;
  assign fall_flag_o        = fall_q;
  assign watchdog_expired_o = wd_q;

  a_wd_needs_fall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && watchdog_expired_o |-> fall_flag_o)
    else $error("watchdog reported without an active fall");

  a_idle_run_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !armed_q |-> run_q == '0)
    else $error("movement run nonzero while no fall is armed");

  a_since_saturates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o && q_head_i.tick && since_q == MsMax |=> since_q == MsMax)
    else $error("elapsed time wrapped");

endmodule

FILE: hw/rtl/fall_detector_with_recovery_watchdog.sv
`timescale 1ns / 1ps
// top level of the fall detector with recovery watchdog
//
// input channel: in_valid_i / in_stall_o carry one word per accepted edge,
// either an accelerometer sample (action_i low, signed q4.12 axes) or a
// one millisecond tick (action_i high, axes ignored)
// output channel: out_valid_o / out_stall_i carry one result word per input
// word, in order: fall_flag_o and watchdog_expired_o after that word
// configuration: cfg_valid_i / cfg_ready_o with cfg_index_i and cfg_data_i;
// ready is always high, unknown indexes are dropped, the user must write
// only while no words are in flight; the block does not enforce it
// path from input accept to result valid: square register loaded at the
// accept edge, then queue write, then state update into the result register
// throughput: one word per cycle while the receiver does not stall, set by
// the state update in the back end; the front stalls once the square stage
// and the four-entry queue together hold four words
// reset: fall state, run and elapsed time clear, registers take their
// defaults, queue and result register empty
// when the receiver stalls, the result holds, the back end stops popping
// and the queue absorbs words until the front raises in_stall_o
module fall_detector_with_recovery_watchdog import fdw_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               action_i,
  input  logic signed [15:0] accel_x_i,
  input  logic signed [15:0] accel_y_i,
  input  logic signed [15:0] accel_z_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               fall_flag_o,
  output logic               watchdog_expired_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i
);

  cfg_t             cfg_q;
  logic             push;
  cls_t             push_word;
  logic             pop;
  logic             q_empty;
  cls_t             q_head;
  logic [QLvlW-1:0] q_level;

  // register file, always ready
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.spike_level_sq       <= SpikeReset;
      cfg_q.band_high_sq         <= BandHighReset;
      cfg_q.band_low_sq          <= BandLowReset;
      cfg_q.moves_to_clear       <= MovesReset;
      cfg_q.no_recovery_limit_ms <= LimitReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        IDX_SPIKE_LEVEL: cfg_q.spike_level_sq       <= cfg_data_i;
        IDX_BAND_HIGH:   cfg_q.band_high_sq         <= cfg_data_i;
        IDX_BAND_LOW:    cfg_q.band_low_sq          <= cfg_data_i;
        IDX_MOVES:       cfg_q.moves_to_clear       <= cfg_data_i[7:0];
        IDX_LIMIT:       cfg_q.no_recovery_limit_ms <= cfg_data_i[23:0];
        default:         ;
      endcase
    end
  end

  // squares and threshold compares
  fdw_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .action_i    (action_i),
    .accel_x_i   (accel_x_i),
    .accel_y_i   (accel_y_i),
    .accel_z_i   (accel_z_i),
    .q_level_i   (q_level),
    .push_o      (push),
    .push_word_o (push_word)
  );

  // decouples the classifier from the state update
  fdw_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_word_i (push_word),
    .pop_i       (pop),
    .empty_o     (q_empty),
    .head_o      (q_head),
    .level_o     (q_level)
  );

  // fall state machine and result register
  fdw_back u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_i              (cfg_q),
    .q_empty_i          (q_empty),
    .q_head_i           (q_head),
    .pop_o              (pop),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .fall_flag_o        (fall_flag_o),
    .watchdog_expired_o (watchdog_expired_o)
  );

endmodule

FILE: test/fall_tb_pkg.sv
`timescale 1ns / 1ps
// codes and result type shared by the fall detector testbench files
package fall_tb_pkg;

  localparam logic ActSample = 1'b0;
  localparam logic ActTick   = 1'b1;

  localparam logic [2:0] IdxUnusedFirst = 3'd5;
  localparam logic [2:0] IdxUnusedLast  = 3'd7;

  typedef struct packed {
    logic fall;
    logic watchdog;
  } verdict_t;

endpackage

FILE: test/fall_verdict_checker.sv
`timescale 1ns / 1ps
// channel monitor with its own fall and watchdog prediction for the fall detector
module fall_verdict_checker import fdw_pkg::*, fall_tb_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic               action_i,
  input  logic signed [15:0] accel_x_i,
  input  logic signed [15:0] accel_y_i,
  input  logic signed [15:0] accel_z_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic               fall_flag_i,
  input  logic               watchdog_expired_i,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  output int                 mismatch_count_o,
  output int                 backlog_o
);

  cfg_t        regs;
  logic        armed;
  logic [7:0]  run_len;
  logic [23:0] elapsed_ms;
  verdict_t    verdict_q[$];
  verdict_t    want;
  int          errors;

  // exact squared magnitude in q8.24, at most 3 * 2^30
  function automatic logic [31:0] magnitude_sq(logic signed [15:0] x, logic signed [15:0] y,
                                               logic signed [15:0] z);
    int     ax;
    int     ay;
    int     az;
    longint total;
    ax = (x < 0) ? -int'(x) : int'(x);
    ay = (y < 0) ? -int'(y) : int'(y);
    az = (z < 0) ? -int'(z) : int'(z);
    total = longint'(ax * ax) + longint'(ay * ay) + longint'(az * az);
    return total[31:0];
  endfunction

  function automatic verdict_t take_word(logic act, logic signed [15:0] x,
                                         logic signed [15:0] y, logic signed [15:0] z);
    logic [31:0] mag;
    verdict_t    v;
    if (act == ActTick) begin
      if (elapsed_ms < MsMax) elapsed_ms = elapsed_ms + 24'd1;
    end else begin
      mag = magnitude_sq(x, y, z);
      if (mag > regs.spike_level_sq && !armed) begin
        armed      = 1'b1;
        elapsed_ms = '0;
        run_len    = '0;
      end
      // the arming sample is judged for movement too
      if (armed) begin
        if (mag > regs.band_high_sq || mag < regs.band_low_sq) begin
          if (run_len < RunMax) run_len = run_len + 8'd1;
        end else begin
          run_len = '0;
        end
        if (run_len >= regs.moves_to_clear) begin
          armed   = 1'b0;
          run_len = '0;
        end
      end
    end
    v.fall     = armed;
    v.watchdog = armed && (elapsed_ms > regs.no_recovery_limit_ms);
    return v;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs       = '{SpikeReset, BandHighReset, BandLowReset, MovesReset, LimitReset};
      armed      = 1'b0;
      run_len    = '0;
      elapsed_ms = '0;
      errors     = 0;
      verdict_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          IDX_SPIKE_LEVEL: regs.spike_level_sq       = cfg_data_i;
          IDX_BAND_HIGH:   regs.band_high_sq         = cfg_data_i;
          IDX_BAND_LOW:    regs.band_low_sq          = cfg_data_i;
          IDX_MOVES:       regs.moves_to_clear       = cfg_data_i[7:0];
          IDX_LIMIT:       regs.no_recovery_limit_ms = cfg_data_i[23:0];
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (verdict_q.size() == 0) begin
          errors++;
          $display("%0t: result word with none expected, fall_flag %0b watchdog_expired %0b",
                   $time, fall_flag_i, watchdog_expired_i);
        end else begin
          want = verdict_q.pop_front();
          if (fall_flag_i !== want.fall) begin
            errors++;
            $display("%0t: fall_flag expected %0b actual %0b", $time, want.fall, fall_flag_i);
          end
          if (watchdog_expired_i !== want.watchdog) begin
            errors++;
            $display("%0t: watchdog_expired expected %0b actual %0b", $time, want.watchdog,
                     watchdog_expired_i);
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        verdict_q.push_back(take_word(action_i, accel_x_i, accel_y_i, accel_z_i));
      end
    end
    mismatch_count_o <= errors;
    backlog_o        <= verdict_q.size();
  end

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps
// drives samples, ticks and register writes into the fall detector and reports the verdict
module testbench;
  import fdw_pkg::*;
  import fall_tb_pkg::*;

  // cycles without any accepted word before the run is called hung
  localparam int unsigned StallLimit  = 4000;
  // settle time after the last result
  localparam int unsigned DrainCycles = 5;
  localparam int unsigned PhaseWords  = 85;

  localparam logic signed [15:0] OneG    = 16'sd4096;
  localparam logic signed [15:0] AxisMin = 16'sh8000;
  localparam logic signed [15:0] AxisMax = 16'sh7FFF;

  logic               clk              = 1'b0;
  logic               rst_n            = 1'b0;
  logic               in_valid         = 1'b0;
  logic               in_stall;
  logic               action           = ActSample;
  logic signed [15:0] accel_x          = '0;
  logic signed [15:0] accel_y          = '0;
  logic signed [15:0] accel_z          = '0;
  logic               out_valid;
  logic               out_stall        = 1'b0;
  logic               fall_flag;
  logic               watchdog_expired;
  logic               cfg_valid        = 1'b0;
  logic               cfg_ready;
  logic [2:0]         cfg_index        = '0;
  logic [31:0]        cfg_data         = '0;

  // high during the stretch where neither side idles
  logic               calm             = 1'b0;
  int                 mismatches;
  int                 backlog;
  int unsigned        idle_cycles      = 0;

  fall_detector_with_recovery_watchdog dut (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .in_valid_i         (in_valid),
    .in_stall_o         (in_stall),
    .action_i           (action),
    .accel_x_i          (accel_x),
    .accel_y_i          (accel_y),
    .accel_z_i          (accel_z),
    .out_valid_o        (out_valid),
    .out_stall_i        (out_stall),
    .fall_flag_o        (fall_flag),
    .watchdog_expired_o (watchdog_expired),
    .cfg_valid_i        (cfg_valid),
    .cfg_ready_o        (cfg_ready),
    .cfg_index_i        (cfg_index),
    .cfg_data_i         (cfg_data)
  );

  fall_verdict_checker verdicts (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .in_valid_i         (in_valid),
    .in_stall_i         (in_stall),
    .action_i           (action),
    .accel_x_i          (accel_x),
    .accel_y_i          (accel_y),
    .accel_z_i          (accel_z),
    .out_valid_i        (out_valid),
    .out_stall_i        (out_stall),
    .fall_flag_i        (fall_flag),
    .watchdog_expired_i (watchdog_expired),
    .cfg_valid_i        (cfg_valid),
    .cfg_ready_i        (cfg_ready),
    .cfg_index_i        (cfg_index),
    .cfg_data_i         (cfg_data),
    .mismatch_count_o   (mismatches),
    .backlog_o          (backlog)
  );

  // 50 MHz
  initial begin
    forever #10 clk = ~clk;
  end

  // single reset pulse at the start of the run
  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
  end

  // receiver stalls at random, about 7 percent of the time, never during the calm stretch
  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(99) < 7);
  end

  // hang detection: any accepted word on any channel restarts the count
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // small signed offset in [-span, span]
  function automatic logic signed [15:0] jitter(int span);
    return 16'(int'($urandom_range(2 * span)) - span);
  endfunction

  // valid stays high from word to word unless the sender idles first
  task automatic send_word(logic act, logic signed [15:0] x, logic signed [15:0] y,
                           logic signed [15:0] z);
    if (!calm && $urandom_range(99) < 7) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    action   <= act;
    accel_x  <= x;
    accel_y  <= y;
    accel_z  <= z;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_sample(logic signed [15:0] x, logic signed [15:0] y,
                             logic signed [15:0] z);
    send_word(ActSample, x, y, z);
  endtask

  // axes carry junk on a tick, they must be ignored
  task automatic send_tick();
    send_word(ActTick, 16'($urandom), 16'($urandom), 16'($urandom));
  endtask

  // mostly plausible wearer motion: rest near 1 g, spikes, free fall, shaking, ticks
  task automatic send_random_word();
    int                 kind;
    int                 axis;
    int                 lift;
    logic               act;
    logic signed [15:0] v[3];
    kind = $urandom_range(99);
    axis = $urandom_range(2);
    act  = ActSample;
    for (int k = 0; k < 3; k++) v[k] = jitter(300);
    if (kind < 30) begin
      act = ActTick;
      for (int k = 0; k < 3; k++) v[k] = 16'($urandom);
    end else if (kind < 55) begin
      // at rest, gravity on one axis
      v[axis] = ($urandom_range(1) ? OneG : -OneG) + jitter(300);
    end else if (kind < 67) begin
      // impact spike
      lift = $urandom_range(32767, 12000);
      for (int k = 0; k < 3; k++) v[k] = jitter(1000);
      v[axis] = 16'($urandom_range(1) ? lift : -lift);
    end else if (kind < 77) begin
      // near free fall, under the band
      for (int k = 0; k < 3; k++) v[k] = jitter(1000);
    end else if (kind < 87) begin
      // shaking, over the band but under the default spike
      lift = $urandom_range(9000, 6000);
      v[axis] = 16'($urandom_range(1) ? lift : -lift);
    end else begin
      for (int k = 0; k < 3; k++) v[k] = 16'($urandom);
    end
    send_word(act, v[0], v[1], v[2]);
  endtask

  task automatic run_random(int words);
    for (int n = 0; n < words; n++) send_random_word();
  endtask

  // drop valid and wait until every expected result is back
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (backlog != 0);
  endtask

  // all five registers plus one write to an unused index, valid held across the burst
  task automatic load_config(cfg_t c);
    logic [2:0]  idx[6];
    logic [31:0] val[6];
    logic [31:0] filler;
    filler = $urandom;
    idx[0] = IDX_SPIKE_LEVEL;
    val[0] = c.spike_level_sq;
    idx[1] = IDX_BAND_HIGH;
    val[1] = c.band_high_sq;
    idx[2] = IDX_BAND_LOW;
    val[2] = c.band_low_sq;
    // upper bits beyond the register width carry junk
    idx[3] = IDX_MOVES;
    val[3] = {filler[31:8], c.moves_to_clear};
    idx[4] = IDX_LIMIT;
    val[4] = {filler[7:0], c.no_recovery_limit_ms};
    idx[5] = 3'($urandom_range(IdxUnusedLast, IdxUnusedFirst));
    val[5] = $urandom;
    for (int k = 0; k < 6; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[k];
      cfg_data  <= val[k];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
  endtask

  initial begin
    wait (rst_n);
    @(posedge clk);

    // reset thresholds: spike above 2.5 g, band 0.7 g to 1.3 g, five moves
    send_sample(16'sd0, 16'sd0, OneG);
    send_tick();
    send_sample(AxisMin, AxisMin, AxisMin);   // largest magnitude arms
    send_sample(AxisMax, AxisMax, AxisMax);   // spike while armed only moves
    send_sample(16'sd0, 16'sd0, 16'sd0);
    send_sample(16'sd0, OneG, 16'sd0);        // back in band, run restarts
    send_sample(16'sd0, 16'sd0, 16'sd0);
    send_sample(AxisMin, 16'sd0, 16'sd0);
    send_tick();                              // ticks do not break the run
    send_sample(16'sd0, 16'sd0, 16'sd0);
    send_sample(16'sd0, AxisMax, 16'sd0);
    send_sample(16'sd0, 16'sd0, 16'sd0);      // fifth move clears
    drain();

    // spike exactly at 3 g must not arm, zero moves clear on the arming sample
    load_config('{32'd150994944, 32'd16777216, 32'd16777216, 8'd0, 24'd0});
    send_sample(16'sd12288, 16'sd0, 16'sd0);
    send_sample(-16'sd12289, 16'sd0, 16'sd0);
    drain();

    // band collapsed onto exactly 1 g, watchdog after more than one tick
    load_config('{32'd150994944, 32'd16777216, 32'd16777216, RunMax, 24'd1});
    send_sample(16'sd0, 16'sd0, -16'sd12289);
    send_tick();
    send_tick();
    send_sample(OneG, 16'sd0, 16'sd0);        // on the band edge is not movement
    send_sample(16'sd0, -OneG, 16'sd0);
    drain();

    // random phases across several settings, extremes among them
    load_config('{SpikeReset, BandHighReset, BandLowReset, 8'd3, 24'd20});
    run_random(PhaseWords);
    drain();

    // everything nonzero arms, nothing is ever movement, watchdog at its ceiling
    load_config('{32'd0, 32'hFFFF_FFFF, 32'd0, 8'd1, MsMax});
    run_random(PhaseWords);
    drain();

    // nothing arms, everything would be movement
    load_config('{32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, RunMax, 24'd0});
    run_random(PhaseWords);
    drain();

    load_config('{32'd0, BandHighReset, BandLowReset, 8'd0, 24'd5});
    run_random(PhaseWords);
    drain();

    // long stretch with both sides streaming
    load_config('{$urandom_range(200000000, 60000000), $urandom_range(40000000, 20000000),
                  $urandom_range(12000000, 0), 8'($urandom_range(8, 1)),
                  24'($urandom_range(60))});
    calm <= 1'b1;
    run_random(PhaseWords);
    drain();
    calm <= 1'b0;

    load_config('{SpikeReset, BandHighReset, BandLowReset, 8'd2, 24'd10});
    run_random(PhaseWords);
    drain();

    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0 && backlog == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
